// ===== hdl/eic_pkg.sv =====
package eic_pkg;

   // Number of interrupt sources and the vector value that means no handler
   localparam int unsigned NUM_SOURCES        = 32;
   localparam logic [31:0] NO_HANDLER_ADDRESS = 32'h0000_0000;

   localparam int unsigned SRC_W       = 5;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [31:0] SOURCE_SPAN = 32'hFFFF_FFFF >> (32 - NUM_SOURCES);

   // Register window offsets
   localparam logic [31:0] OFS_STATUS  = 32'h0000_0000;
   localparam logic [31:0] OFS_MASK    = 32'h0000_0004;
   localparam logic [31:0] OFS_PENDING = 32'h0000_0008;
   localparam logic [31:0] OFS_SOURCE  = 32'h0000_000c;
   localparam logic [31:0] OFS_SLEEP   = 32'h0000_0010;
   localparam logic [31:0] OFS_FLUSH   = 32'h0000_0014;
   localparam logic [24:0] VEC_PAGE    = 25'h000_0001;

   localparam logic [2:0] WORD_SIZE = 3'd4;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE   = 2'd1;

   typedef enum logic [2:0] {
      MODE_READ   = 3'd0,
      MODE_WRITE  = 3'd1,
      MODE_FAULT  = 3'd2,
      MODE_TAKE   = 3'd3,
      MODE_TRAP   = 3'd4,
      MODE_RETURN = 3'd5
   } mode_type;

   typedef enum logic [2:0] {
      ERR_OK           = 3'd0,
      ERR_UNALIGNED    = 3'd1,
      ERR_UNMAPPED     = 3'd2,
      ERR_READ_ONLY    = 3'd3,
      ERR_UNHANDLED    = 3'd4,
      ERR_NONE_PENDING = 3'd5
   } err_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;
      logic lookup;
      logic execute;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic out_free;
   } stat_type;

endpackage

// ===== hdl/exception_interrupt_controller.sv =====
// Channel   Direction  Handshake          Contents
// req_      in         req_valid/ready    mode, bus address, size, write data, index
// rsp_      out        rsp_valid/ready    read data, handler, flush pulses, error, request
// csr_      in         csr_valid/ready    register index, write data
//
// Each item passes capture, vector table lookup through the registered RAM
// read port, and execute; a new item is accepted only after the last has
// executed. Execute waits only while the previous result is still held in
// the output register. Reset is synchronous; vector valid bits clear at
// once, no clearing pass. The configuration port is always ready.
module exception_interrupt_controller (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [2:0]                       req_mode,
   input  logic [31:0]                      req_bus_address,
   input  logic [2:0]                       req_access_size,
   input  logic [31:0]                      req_write_data,
   input  logic [4:0]                       req_exception_index,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [31:0]                      rsp_read_data,
   output logic                             rsp_handler_taken,
   output logic [4:0]                       rsp_handler_number,
   output logic [31:0]                      rsp_handler_address,
   output logic                             rsp_flush_data_caches,
   output logic                             rsp_flush_instr_cache,
   output logic [2:0]                       rsp_error_code,
   output logic                             rsp_interrupt_request,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [eic_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [31:0]                      csr_write_data
);
   import eic_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   eic_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   eic_datapath u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .stat                  (stat),
      .req_mode              (req_mode),
      .req_bus_address       (req_bus_address),
      .req_access_size       (req_access_size),
      .req_write_data        (req_write_data),
      .req_exception_index   (req_exception_index),
      .csr_valid             (csr_valid),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_read_data         (rsp_read_data),
      .rsp_handler_taken     (rsp_handler_taken),
      .rsp_handler_number    (rsp_handler_number),
      .rsp_handler_address   (rsp_handler_address),
      .rsp_flush_data_caches (rsp_flush_data_caches),
      .rsp_flush_instr_cache (rsp_flush_instr_cache),
      .rsp_error_code        (rsp_error_code),
      .rsp_interrupt_request (rsp_interrupt_request)
   );

endmodule

// ===== hdl/eic_controller.sv =====
module eic_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  eic_pkg::stat_type stat,
   output eic_pkg::cmd_type  cmd
);
   import eic_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_LOOKUP = 3'b010,
      S_EXEC   = 3'b100
   } state_type;

   state_type state_ff, state_in;

   assign req_ready   = (state_ff == S_IDLE);
   assign cmd.capture = req_valid && req_ready;
   assign cmd.lookup  = (state_ff == S_LOOKUP);
   assign cmd.execute = (state_ff == S_EXEC) && stat.out_free;

   // Advance: capture, vector lookup, execute once the result register is free
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:   if (cmd.capture) state_in = S_LOOKUP;
         S_LOOKUP: state_in = S_EXEC;
         S_EXEC:   if (cmd.execute) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hdl/eic_datapath.sv =====
module eic_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  eic_pkg::cmd_type                 cmd,
   output eic_pkg::stat_type                stat,
   input  logic [2:0]                       req_mode,
   input  logic [31:0]                      req_bus_address,
   input  logic [2:0]                       req_access_size,
   input  logic [31:0]                      req_write_data,
   input  logic [4:0]                       req_exception_index,
   input  logic                             csr_valid,
   input  logic [eic_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [31:0]                      csr_write_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [31:0]                      rsp_read_data,
   output logic                             rsp_handler_taken,
   output logic [4:0]                       rsp_handler_number,
   output logic [31:0]                      rsp_handler_address,
   output logic                             rsp_flush_data_caches,
   output logic                             rsp_flush_instr_cache,
   output logic [2:0]                       rsp_error_code,
   output logic                             rsp_interrupt_request
);
   import eic_pkg::*;

   // Lowest set bit, priority encoder
   function automatic logic [SRC_W-1:0] lowest_set(input logic [31:0] w);
      logic [SRC_W-1:0] n;
      n = SRC_W'(31);
      for (int i = 30; i >= 0; i--) begin
         if (w[i]) n = SRC_W'(i);
      end
      return n;
   endfunction

   // Configuration
   logic        enable_ff;
   logic [31:0] base_ff;

   // Architectural state
   logic [31:0]           status_ff, status_in;
   logic [31:0]           mask_ff, mask_in;
   logic [31:0]           pending_ff, pending_in;
   logic [SRC_W-1:0]      source_ff, source_in;
   logic [NUM_SOURCES-1:0] vec_valid_ff;
   logic [31:0]           vec_mem [NUM_SOURCES];

   // Captured item
   logic [2:0]       mode_ff;
   logic [31:0]      addr_ff;
   logic [2:0]       size_ff;
   logic [31:0]      wdata_ff;
   logic [SRC_W-1:0] exc_ff;

   // Lookup stage
   logic [31:0]      ofs_lk;
   logic [31:0]      waiting;
   logic [SRC_W-1:0] raddr;
   logic [31:0]      ofs_ff;
   logic [SRC_W-1:0] sel_ff;
   logic [31:0]      vq_ff;
   logic             vvalid_ff;
   logic [31:0]      entry;

   // Execute results
   logic [31:0]      rd;
   logic             taken;
   logic [SRC_W-1:0] hnum;
   logic [31:0]      haddr;
   logic             fd, fi;
   err_type          err;
   logic             irq;
   logic             vec_we;
   logic [SRC_W-1:0] vec_idx;
   logic             word;
   logic             in_vec;
   logic             exc_ok;
   err_type          slot_err;

   // Result register
   logic        rsp_valid_ff;
   logic [31:0] rd_ff, haddr_ff;
   logic        taken_ff, fd_ff, fi_ff, irq_ff;
   logic [4:0]  hnum_ff;
   logic [2:0]  err_ff;

   assign stat.out_free = !rsp_valid_ff || rsp_ready;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b1;
         base_ff   <= 32'h0;
      end else if (csr_valid) begin
         if (csr_index == CSR_ENABLE) enable_ff <= csr_write_data[0];
         if (csr_index == CSR_BASE)   base_ff   <= csr_write_data;
      end
   end

   // Hold the accepted item
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff  <= req_mode;
         addr_ff  <= req_bus_address;
         size_ff  <= req_access_size;
         wdata_ff <= req_write_data;
         exc_ff   <= req_exception_index;
      end
   end

   // Pick the vector entry the item needs
   assign ofs_lk  = addr_ff - base_ff;
   assign waiting = pending_ff & mask_ff & SOURCE_SPAN;

   always_comb begin
      case (mode_ff)
         MODE_READ, MODE_WRITE: raddr = ofs_lk[SRC_W+1:2];
         MODE_TAKE:             raddr = lowest_set(waiting);
         default:               raddr = exc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         ofs_ff    <= ofs_lk;
         sel_ff    <= lowest_set(waiting);
         vq_ff     <= vec_mem[raddr];
         vvalid_ff <= vec_valid_ff[raddr];
      end
   end

   assign entry = vvalid_ff ? vq_ff : NO_HANDLER_ADDRESS;

   // Execute the operation
   assign word    = (size_ff == WORD_SIZE);
   assign in_vec  = (ofs_ff[31:7] == VEC_PAGE);
   assign vec_idx = ofs_ff[SRC_W+1:2];
   assign exc_ok  = ({1'b0, exc_ff} < (SRC_W+1)'(NUM_SOURCES));

   always_comb begin
      if (ofs_ff[1:0] != 2'b00 || !word)
         slot_err = ERR_UNALIGNED;
      else if ({1'b0, vec_idx} >= (SRC_W+1)'(NUM_SOURCES))
         slot_err = ERR_UNMAPPED;
      else
         slot_err = ERR_OK;
   end

   always_comb begin
      status_in  = status_ff;
      mask_in    = mask_ff;
      pending_in = pending_ff;
      source_in  = source_ff;
      rd         = 32'h0;
      taken      = 1'b0;
      hnum       = '0;
      haddr      = 32'h0;
      fd         = 1'b0;
      fi         = 1'b0;
      err        = ERR_OK;
      vec_we     = 1'b0;
      case (mode_ff)
         MODE_READ: begin
            if (word && ofs_ff == OFS_STATUS)       rd = status_ff;
            else if (word && ofs_ff == OFS_MASK)    rd = mask_ff;
            else if (word && ofs_ff == OFS_PENDING) rd = pending_ff;
            else if (word && ofs_ff == OFS_SOURCE)  rd = 32'(source_ff);
            else if (in_vec) begin
               err = slot_err;
               if (slot_err == ERR_OK) rd = entry;
            end else err = ERR_UNMAPPED;
         end
         MODE_WRITE: begin
            if (word && ofs_ff == OFS_STATUS)       status_in  = wdata_ff;
            else if (word && ofs_ff == OFS_MASK)    mask_in    = wdata_ff;
            else if (word && ofs_ff == OFS_PENDING) pending_in = wdata_ff;
            else if (word && ofs_ff == OFS_SOURCE)  err = ERR_READ_ONLY;
            else if (word && ofs_ff == OFS_SLEEP)   err = ERR_OK;
            else if (word && ofs_ff == OFS_FLUSH) begin
               fd = wdata_ff[0];
               fi = wdata_ff[1];
            end else if (in_vec) begin
               err    = slot_err;
               vec_we = (slot_err == ERR_OK);
            end else err = ERR_UNMAPPED;
         end
         MODE_FAULT: begin
            if (enable_ff && exc_ok && entry != NO_HANDLER_ADDRESS)
               pending_in = pending_ff | (32'h1 << exc_ff);
            else
               err = ERR_UNHANDLED;
         end
         MODE_TAKE: begin
            if (!(enable_ff && status_ff[0] && waiting != 32'h0)) begin
               err = ERR_NONE_PENDING;
            end else begin
               source_in  = sel_ff;
               pending_in = pending_ff & ~(32'h1 << sel_ff);
               status_in  = {status_ff[30:0], 1'b0};
               taken      = 1'b1;
               hnum       = sel_ff;
               haddr      = entry;
            end
         end
         MODE_TRAP: begin
            if (exc_ok && mask_ff[exc_ff]) begin
               source_in = exc_ff;
               status_in = {status_ff[30:0], 1'b0};
               taken     = 1'b1;
               hnum      = exc_ff;
               haddr     = entry;
            end
         end
         MODE_RETURN: status_in = {1'b0, status_ff[31:1]};
         default: ;
      endcase
   end

   assign irq = enable_ff && status_in[0] && ((pending_in & mask_in & SOURCE_SPAN) != 32'h0);

   // Commit state
   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff    <= 32'h0;
         mask_ff      <= 32'h0;
         pending_ff   <= 32'h0;
         source_ff    <= '0;
         vec_valid_ff <= '0;
      end else if (cmd.execute) begin
         status_ff  <= status_in;
         mask_ff    <= mask_in;
         pending_ff <= pending_in;
         source_ff  <= source_in;
         if (vec_we) vec_valid_ff[vec_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute && vec_we) vec_mem[vec_idx] <= wdata_ff;
   end

   // Result register, drop on transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.execute) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         rd_ff    <= rd;
         taken_ff <= taken;
         hnum_ff  <= hnum;
         haddr_ff <= haddr;
         fd_ff    <= fd;
         fi_ff    <= fi;
         err_ff   <= err;
         irq_ff   <= irq;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_read_data         = rd_ff;
   assign rsp_handler_taken     = taken_ff;
   assign rsp_handler_number    = hnum_ff;
   assign rsp_handler_address   = haddr_ff;
   assign rsp_flush_data_caches = fd_ff;
   assign rsp_flush_instr_cache = fi_ff;
   assign rsp_error_code        = err_ff;
   assign rsp_interrupt_request = irq_ff;

endmodule

// ===== hdl/eic_checker.sv =====
module eic_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_read_data,
   input logic        rsp_handler_taken,
   input logic [4:0]  rsp_handler_number,
   input logic [31:0] rsp_handler_address,
   input logic        rsp_flush_data_caches,
   input logic        rsp_flush_instr_cache,
   input logic [2:0]  rsp_error_code
);
   import eic_pkg::*;

   // Hold a result until its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before transfer");

   // No result straight after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Entering a handler is never an error
   a_taken_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_handler_taken |-> rsp_error_code == ERR_OK)
      else $error("handler taken with an error code");

   // Handler fields stay clear when no handler is entered
   a_no_handler: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_handler_taken |->
         rsp_handler_number == 5'd0 && rsp_handler_address == 32'h0)
      else $error("handler fields set without a handler");

   // Flush pulses come only from a clean write
   a_flush_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_flush_data_caches || rsp_flush_instr_cache) |->
         !rsp_handler_taken && rsp_read_data == 32'h0 && rsp_error_code == ERR_OK)
      else $error("flush pulse outside a flush write");

endmodule

bind exception_interrupt_controller eic_checker u_eic_checker (.*);

// ===== tb/exception_interrupt_controller_tb.sv =====
module exception_interrupt_controller_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import eic_pkg::*;

   localparam int unsigned STUCK_LIMIT  = 1000;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned PHASE_ITEMS  = 250;

   localparam logic [31:0] VEC_LO = 32'h0000_0080;
   localparam logic [31:0] VEC_HI = 32'h0000_0100;

   // Modes with no operation behind them
   localparam logic [2:0] MODE_SPARE_LO = 3'd6;
   localparam logic [2:0] MODE_SPARE_HI = 3'd7;

   localparam logic [31:0] REG_OFFSETS [6] =
      '{OFS_STATUS, OFS_MASK, OFS_PENDING, OFS_SOURCE, OFS_SLEEP, OFS_FLUSH};

   typedef struct packed {
      logic [2:0]  mode;
      logic [31:0] addr;
      logic [2:0]  size;
      logic [31:0] data;
      logic [4:0]  index;
   } bus_op_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        taken;
      logic [4:0]  number;
      logic [31:0] address;
      logic        flush_d;
      logic        flush_i;
      logic [2:0]  err;
      logic        irq;
   } outcome_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [2:0]             req_mode = '0;
   logic [31:0]            req_bus_address = '0;
   logic [2:0]             req_access_size = '0;
   logic [31:0]            req_write_data = '0;
   logic [4:0]             req_exception_index = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [31:0]            rsp_read_data;
   logic                   rsp_handler_taken;
   logic [4:0]             rsp_handler_number;
   logic [31:0]            rsp_handler_address;
   logic                   rsp_flush_data_caches;
   logic                   rsp_flush_instr_cache;
   logic [2:0]             rsp_error_code;
   logic                   rsp_interrupt_request;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [31:0]            csr_write_data = '0;

   exception_interrupt_controller uut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_mode              (req_mode),
      .req_bus_address       (req_bus_address),
      .req_access_size       (req_access_size),
      .req_write_data        (req_write_data),
      .req_exception_index   (req_exception_index),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_read_data         (rsp_read_data),
      .rsp_handler_taken     (rsp_handler_taken),
      .rsp_handler_number    (rsp_handler_number),
      .rsp_handler_address   (rsp_handler_address),
      .rsp_flush_data_caches (rsp_flush_data_caches),
      .rsp_flush_instr_cache (rsp_flush_instr_cache),
      .rsp_error_code        (rsp_error_code),
      .rsp_interrupt_request (rsp_interrupt_request),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data)
   );

   // Shadow copy of the exception unit
   logic        m_enable = 1'b1;
   logic [31:0] m_base = '0;
   logic [31:0] m_status = '0;
   logic [31:0] m_mask = '0;
   logic [31:0] m_pending = '0;
   logic [4:0]  m_source = '0;
   logic [31:0] m_vectors [NUM_SOURCES];

   bus_op_type  ops_pending [$];
   outcome_type outcomes_due [$];
   logic [31:0] phase_base = '0;
   logic        quiet = 1'b0;
   logic        req_done = 1'b0;
   int          req_gap = 0;
   int          stall_left = 0;
   int          stuck_cycles = 0;
   int          mismatches = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic irq_line();
      return m_enable && m_status[0] && ((m_pending & m_mask & SOURCE_SPAN) != 0);
   endfunction

   // Apply one operation to the shadow state and return the result it gives
   function automatic outcome_type resolve_request(input bus_op_type op);
      outcome_type o;
      logic [31:0] ofs;
      logic [31:0] slot;
      logic [31:0] waiting;
      logic [2:0]  vec_err;
      logic        word;
      logic        vec_hit;
      logic [4:0]  pick;
      o = '0;
      pick = '0;
      ofs = op.addr - m_base;
      word = (op.size == WORD_SIZE);
      vec_hit = (ofs >= VEC_LO) && (ofs < VEC_HI);
      slot = (ofs - VEC_LO) >> 2;
      if (ofs[1:0] != 2'b00 || !word) vec_err = ERR_UNALIGNED;
      else if (slot >= NUM_SOURCES) vec_err = ERR_UNMAPPED;
      else vec_err = ERR_OK;

      case (op.mode)
         MODE_READ: begin
            if (word && ofs == OFS_STATUS) o.read_data = m_status;
            else if (word && ofs == OFS_MASK) o.read_data = m_mask;
            else if (word && ofs == OFS_PENDING) o.read_data = m_pending;
            else if (word && ofs == OFS_SOURCE) o.read_data = {27'b0, m_source};
            else if (vec_hit) begin
               o.err = vec_err;
               if (vec_err == ERR_OK) o.read_data = m_vectors[slot[4:0]];
            end else o.err = ERR_UNMAPPED;
         end
         MODE_WRITE: begin
            if (word && ofs == OFS_STATUS) m_status = op.data;
            else if (word && ofs == OFS_MASK) m_mask = op.data;
            else if (word && ofs == OFS_PENDING) m_pending = op.data;
            else if (word && ofs == OFS_SOURCE) o.err = ERR_READ_ONLY;
            else if (word && ofs == OFS_SLEEP) begin
               // sleep request has no visible effect
            end else if (word && ofs == OFS_FLUSH) begin
               o.flush_d = op.data[0];
               o.flush_i = op.data[1];
            end else if (vec_hit) begin
               o.err = vec_err;
               if (vec_err == ERR_OK) m_vectors[slot[4:0]] = op.data;
            end else o.err = ERR_UNMAPPED;
         end
         MODE_FAULT: begin
            if (m_enable && op.index < NUM_SOURCES &&
                m_vectors[op.index] != NO_HANDLER_ADDRESS)
               m_pending[op.index] = 1'b1;
            else o.err = ERR_UNHANDLED;
         end
         MODE_TAKE: begin
            if (!irq_line()) o.err = ERR_NONE_PENDING;
            else begin
               // lowest waiting source wins
               waiting = m_pending & m_mask & SOURCE_SPAN;
               for (int b = 31; b >= 0; b--) if (waiting[b]) pick = 5'(b);
               m_source = pick;
               m_pending[pick] = 1'b0;
               m_status = m_status << 1;
               o.taken = 1'b1;
               o.number = pick;
               o.address = m_vectors[pick];
            end
         end
         MODE_TRAP: begin
            if (op.index < NUM_SOURCES && m_mask[op.index]) begin
               m_source = op.index;
               m_status = m_status << 1;
               o.taken = 1'b1;
               o.number = op.index;
               o.address = m_vectors[op.index];
            end
         end
         MODE_RETURN: m_status = m_status >> 1;
         default: begin
         end
      endcase
      o.irq = irq_line();
      return o;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h, got %h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   task automatic post_op(input logic [2:0] mode, input logic [31:0] offset,
                          input logic [2:0] size, input logic [31:0] data,
                          input logic [4:0] index);
      bus_op_type op;
      op.mode = mode;
      op.addr = phase_base + offset;
      op.size = size;
      op.data = data;
      op.index = index;
      ops_pending.push_back(op);
   endtask

   // Mostly bus traffic aimed at the window, plus handler entry sequences
   task automatic post_random_ops(input int count);
      bus_op_type  op;
      logic [31:0] ofs;
      int          pick;
      int          k;
      int          n;
      n = 0;
      while (n < count) begin
         if ($urandom_range(0, 9) == 0) begin
            k = $urandom_range(0, NUM_SOURCES - 1);
            post_op(MODE_WRITE, VEC_LO + 4 * k, WORD_SIZE, $urandom | 32'h1, '0);
            post_op(MODE_WRITE, OFS_MASK, WORD_SIZE, $urandom | (32'h1 << k), '0);
            post_op(MODE_FAULT, $urandom, 3'($urandom_range(0, 4)), $urandom, 5'(k));
            post_op(MODE_WRITE, OFS_STATUS, WORD_SIZE, $urandom | 32'h1, '0);
            post_op(MODE_TAKE, $urandom, 3'($urandom_range(0, 4)), $urandom,
                    5'($urandom));
            post_op(MODE_RETURN, $urandom, 3'($urandom_range(0, 4)), $urandom,
                    5'($urandom));
            n += 6;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 22) op.mode = MODE_READ;
            else if (pick < 47) op.mode = MODE_WRITE;
            else if (pick < 65) op.mode = MODE_FAULT;
            else if (pick < 80) op.mode = MODE_TAKE;
            else if (pick < 90) op.mode = MODE_TRAP;
            else if (pick < 98) op.mode = MODE_RETURN;
            else op.mode = 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));

            pick = $urandom_range(0, 9);
            if (pick < 4) ofs = REG_OFFSETS[$urandom_range(0, 5)];
            else if (pick < 7) ofs = VEC_LO + 4 * $urandom_range(0, NUM_SOURCES - 1);
            else if (pick == 7) ofs = $urandom_range(VEC_LO, VEC_HI - 1);
            else ofs = $urandom_range(0, VEC_LO - 1);
            op.addr = (pick == 9) ? $urandom : phase_base + ofs;

            op.size = ($urandom_range(0, 6) == 0) ? 3'($urandom_range(0, 4)) : WORD_SIZE;
            op.data = ($urandom_range(0, 9) == 0) ? 32'h0 : $urandom;
            op.index = 5'($urandom_range(0, 31));
            ops_pending.push_back(op);
            n++;
         end
      end
   endtask

   task automatic set_register(input logic [CSR_INDEX_W-1:0] index,
                               input logic [31:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_write_data <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Wait until every queued request is through and every result is back
   task automatic wait_drained();
      while (ops_pending.size() != 0 || req_valid || outcomes_due.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Present queued requests; hold each until its transfer completes
   always @(negedge clock) begin : request_driver
      bus_op_type op;
      if (reset || (req_valid && !req_done)) begin
         // hold the current transfer
      end else if (req_gap > 0) begin
         req_gap--;
         req_valid <= 1'b0;
      end else if (ops_pending.size() != 0) begin
         op = ops_pending.pop_front();
         req_valid <= 1'b1;
         req_mode <= op.mode;
         req_bus_address <= op.addr;
         req_access_size <= op.size;
         req_write_data <= op.data;
         req_exception_index <= op.index;
         if (!quiet && $urandom_range(0, 5) == 0) req_gap = $urandom_range(1, 15);
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Stall the result channel in random bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (!quiet && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 15);
      end
   end

   // Sample transfers, predict on requests, check results, watch for hangs
   always @(posedge clock) begin : result_monitor
      outcome_type due;
      bus_op_type  op;
      req_done = req_valid && req_ready;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (outcomes_due.size() == 0) begin
               $display("%0t: result with nothing expected, read_data %h error %0d",
                        $time, rsp_read_data, rsp_error_code);
               mismatches++;
            end else begin
               due = outcomes_due.pop_front();
               check_field("read_data", due.read_data, rsp_read_data);
               check_field("handler_taken", 32'(due.taken), 32'(rsp_handler_taken));
               check_field("handler_number", 32'(due.number), 32'(rsp_handler_number));
               check_field("handler_address", due.address, rsp_handler_address);
               check_field("flush_data_caches", 32'(due.flush_d),
                           32'(rsp_flush_data_caches));
               check_field("flush_instr_cache", 32'(due.flush_i),
                           32'(rsp_flush_instr_cache));
               check_field("error_code", 32'(due.err), 32'(rsp_error_code));
               check_field("interrupt_request", 32'(due.irq),
                           32'(rsp_interrupt_request));
            end
         end
         if (req_done) begin
            op.mode = req_mode;
            op.addr = req_bus_address;
            op.size = req_access_size;
            op.data = req_write_data;
            op.index = req_exception_index;
            outcomes_due.push_back(resolve_request(op));
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_ENABLE) m_enable = csr_write_data[0];
            else if (csr_index == CSR_BASE) m_base = csr_write_data;
         end

         if (req_done || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            stuck_cycles = 0;
         else stuck_cycles++;
         if (stuck_cycles >= STUCK_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, stuck_cycles);
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   initial begin : stimulus
      logic [31:0] bases [5];
      logic        enables [5];
      for (int i = 0; i < NUM_SOURCES; i++) m_vectors[i] = NO_HANDLER_ADDRESS;
      bases = '{$urandom, 32'hFFFF_FFFF, 32'hFFFF_FFC0, 32'h0000_0000, $urandom};
      enables = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1};

      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // Directed pass with the window at zero
      set_register(CSR_ENABLE, 32'h1);
      set_register(CSR_BASE, 32'h0);
      phase_base = 32'h0;
      post_op(MODE_READ, OFS_STATUS, WORD_SIZE, '0, '0);
      post_op(MODE_WRITE, VEC_LO, WORD_SIZE, 32'hFFFF_FFFF, '0);
      post_op(MODE_WRITE, VEC_HI - 4, WORD_SIZE, 32'h8000_0004, '0);
      post_op(MODE_READ, VEC_HI - 4, WORD_SIZE, '0, '0);
      // entry never written reads as no handler
      post_op(MODE_READ, VEC_LO + 20, WORD_SIZE, '0, '0);
      post_op(MODE_WRITE, OFS_MASK, WORD_SIZE, 32'hFFFF_FFFF, '0);
      post_op(MODE_WRITE, OFS_STATUS, WORD_SIZE, 32'h8000_0001, '0);
      post_op(MODE_FAULT, '0, '0, '0, 5'd31);
      post_op(MODE_FAULT, '0, '0, '0, 5'd0);
      // fault on a source without a handler
      post_op(MODE_FAULT, '0, '0, '0, 5'd7);
      post_op(MODE_TAKE, '0, '0, '0, '0);
      // status bit 0 now clear, nothing can be taken
      post_op(MODE_TAKE, '0, '0, '0, '0);
      post_op(MODE_RETURN, '0, '0, '0, '0);
      post_op(MODE_READ, OFS_SOURCE, WORD_SIZE, '0, '0);
      post_op(MODE_WRITE, OFS_SOURCE, WORD_SIZE, 32'hFFFF_FFFF, '0);
      post_op(MODE_WRITE, OFS_SLEEP, WORD_SIZE, 32'hFFFF_FFFF, '0);
      post_op(MODE_WRITE, OFS_FLUSH, WORD_SIZE, 32'h0000_0001, '0);
      post_op(MODE_WRITE, OFS_FLUSH, WORD_SIZE, 32'hFFFF_FFFE, '0);
      post_op(MODE_READ, OFS_FLUSH, WORD_SIZE, '0, '0);
      post_op(MODE_READ, OFS_SLEEP, WORD_SIZE, '0, '0);
      post_op(MODE_READ, VEC_LO + 2, WORD_SIZE, '0, '0);
      post_op(MODE_WRITE, VEC_LO + 4, 3'd2, 32'h1234_5678, '0);
      post_op(MODE_READ, OFS_MASK, 3'd0, '0, '0);
      post_op(MODE_READ, 32'hFFFF_FFFF, WORD_SIZE, '0, '0);
      post_op(MODE_TRAP, '0, '0, '0, 5'd31);
      post_op(MODE_WRITE, OFS_MASK, WORD_SIZE, 32'h0, '0);
      // trap on a masked source
      post_op(MODE_TRAP, '0, '0, '0, 5'd3);
      post_op(MODE_SPARE_LO, '0, '0, '0, '0);
      post_op(MODE_SPARE_HI, 32'hFFFF_FFFF, 3'd4, 32'hFFFF_FFFF, 5'd31);
      wait_drained();

      // Global enable off: faults and takes are refused
      set_register(CSR_ENABLE, 32'h0);
      post_op(MODE_FAULT, '0, '0, '0, 5'd31);
      post_op(MODE_WRITE, OFS_MASK, WORD_SIZE, 32'hFFFF_FFFF, '0);
      post_op(MODE_TAKE, '0, '0, '0, '0);

      // Random phases over several enable and base settings, last one unstalled
      for (int p = 0; p < 5; p++) begin
         wait_drained();
         set_register(CSR_ENABLE, {31'b0, enables[p]});
         set_register(CSR_BASE, bases[p]);
         phase_base = bases[p];
         quiet = (p == 4);
         post_random_ops(PHASE_ITEMS);
      end

      wait_drained();
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
